@@ src/ipv4_acl_pkg.sv @@
// Shared types, sizes and codes for the IPv4 access list block.
`timescale 1ns / 1ps

package ipv4_acl_pkg;

  // Table size and the widths that follow from it
  localparam int TABLE_DEPTH = 128;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_W     = 64;

  // Command codes
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_CHECK = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_BAD_PREFIX = 2'd1;
  localparam logic [1:0] ERR_FULL       = 2'd2;

  // Longest legal prefix
  localparam logic [5:0] MAX_PREFIX = 6'd32;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] address;
    logic        has_prefix;
    logic [5:0]  prefix_len;
  } cmd_beat_t;

  typedef struct packed {
    logic       allowed;
    logic [1:0] error;
    logic [7:0] rule_count;
  } rsp_beat_t;

  // Report the rule count modulo 256
  function automatic logic [7:0] count_out(input logic [COUNT_W-1:0] total);
    logic [31:0] wide;
    wide = 32'(total);
    return wide[7:0];
  endfunction

endpackage

@@ src/ipv4_acl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ipv4_acl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/ipv4_acl_prefix_match.sv @@
// Top level of the IPv4 access list: command sequencer, rule table and matcher.
`timescale 1ns / 1ps

// IPv4 access list with prefix matching. Each command beat clears the table,
// adds a rule (explicit prefix 0..32 or classful default, host mask when the
// address has bits outside the classful mask) or checks an address. Exactly
// one response beat follows each command. Clear, add and unknown commands go
// straight to the done state and then to the response register; a check on a
// filled table has one shared compare unit walk the rule RAM one entry a cycle
// (registered read) and stops at the first match; a check on an empty table
// goes straight to the done state. The block takes no new command until the current one has
// been handed to the response register, which may still hold a beat waiting
// on rsp_stall while the next command is accepted. No clearing pass is needed:
// the fill count marks which entries are live.
module ipv4_acl_prefix_match (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_stall,
  input  ipv4_acl_pkg::cmd_beat_t cmd_beat,
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output ipv4_acl_pkg::rsp_beat_t rsp_beat
);

  import ipv4_acl_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]         state, state_next;
  logic [COUNT_W-1:0] total, total_next;
  logic [COUNT_W-1:0] scan_idx, scan_idx_next;
  logic               rd_live, rd_live_next;
  logic [31:0]        key, key_next;
  logic               res_allowed, res_allowed_next;
  logic [1:0]         res_error, res_error_next;
  logic               rsp_valid_next;
  rsp_beat_t          rsp_beat_next;

  logic               accept;
  logic               slot_free;
  logic               scan_issue;
  logic               scan_match;
  logic [31:0]        add_mask;
  logic               wr_en;
  logic [ENTRY_W-1:0] rd_data;
  logic [31:0]        rd_addr_val;
  logic [31:0]        rd_mask_val;

  // Classful default, widened to a host mask when host bits are set
  function automatic logic [31:0] classful_mask(input logic [31:0] a);
    logic [31:0] m;
    if (!a[31]) begin
      m = 32'hff00_0000;
    end else if (!a[30]) begin
      m = 32'hffff_0000;
    end else begin
      m = 32'hffff_ff00;
    end
    if ((a & m) != a) begin
      m = 32'hffff_ffff;
    end
    return m;
  endfunction

  // Mask of a prefix length from 0 to 32
  function automatic logic [31:0] prefix_mask(input logic [5:0] bits);
    logic [5:0] sh;
    sh = MAX_PREFIX - bits;
    if (bits == 6'd0) begin
      return 32'h0;
    end
    return 32'hffff_ffff << sh[4:0];
  endfunction

  assign accept     = cmd_valid && !cmd_stall;
  assign cmd_stall  = (state != S_IDLE);
  assign slot_free  = !rsp_valid || !rsp_stall;
  assign add_mask   = cmd_beat.has_prefix ? prefix_mask(cmd_beat.prefix_len)
                                          : classful_mask(cmd_beat.address);
  assign wr_en      = accept && (cmd_beat.cmd == CMD_ADD) &&
                      !(cmd_beat.has_prefix && (cmd_beat.prefix_len > MAX_PREFIX)) &&
                      (total < COUNT_W'(TABLE_DEPTH));
  assign scan_issue = (state == S_SCAN) && (scan_idx < total);

  // Rule table: masked address in the upper half, mask in the lower half
  ipv4_acl_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_rules (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(total[IDX_W-1:0]),
    .wr_data({cmd_beat.address & add_mask, add_mask}),
    .rd_en  (scan_issue),
    .rd_addr(scan_idx[IDX_W-1:0]),
    .rd_data(rd_data)
  );

  // Shared compare unit over the entry just read
  assign rd_addr_val = rd_data[ENTRY_W-1:32];
  assign rd_mask_val = rd_data[31:0];
  assign scan_match  = ((key & rd_mask_val) == rd_addr_val);

  // Sequencer
  always_comb begin
    state_next       = state;
    total_next       = total;
    scan_idx_next    = scan_idx;
    rd_live_next     = 1'b0;
    key_next         = key;
    res_allowed_next = res_allowed;
    res_error_next   = res_error;
    rsp_valid_next   = rsp_valid && rsp_stall;
    rsp_beat_next    = rsp_beat;
    case (state)
      S_IDLE: begin
        if (accept) begin
          res_allowed_next = 1'b0;
          res_error_next   = ERR_NONE;
          state_next       = S_DONE;
          case (cmd_beat.cmd)
            CMD_CLEAR: begin
              total_next = '0;
            end
            CMD_ADD: begin
              if (cmd_beat.has_prefix && (cmd_beat.prefix_len > MAX_PREFIX)) begin
                res_error_next = ERR_BAD_PREFIX;
              end else if (!wr_en) begin
                res_error_next = ERR_FULL;
              end else begin
                total_next       = COUNT_W'(total + 1'b1);
                res_allowed_next = 1'b1;
              end
            end
            CMD_CHECK: begin
              if (total == '0) begin
                res_allowed_next = 1'b1;
              end else begin
                key_next      = cmd_beat.address;
                scan_idx_next = '0;
                state_next    = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        // Advance one entry a cycle; stop on a hit or after the last entry
        rd_live_next = scan_issue;
        if (scan_issue) begin
          scan_idx_next = COUNT_W'(scan_idx + 1'b1);
        end
        if (rd_live && (scan_match || (scan_idx == total))) begin
          res_allowed_next = scan_match;
          res_error_next   = ERR_NONE;
          rd_live_next     = 1'b0;
          state_next       = S_DONE;
        end
      end
      S_DONE: begin
        // Hand the result to the response register once it is free
        if (slot_free) begin
          rsp_valid_next           = 1'b1;
          rsp_beat_next.allowed    = res_allowed;
          rsp_beat_next.error      = res_error;
          rsp_beat_next.rule_count = count_out(total);
          state_next               = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      total     <= '0;
      rd_live   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      total     <= total_next;
      rd_live   <= rd_live_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    scan_idx    <= scan_idx_next;
    key         <= key_next;
    res_allowed <= res_allowed_next;
    res_error   <= res_error_next;
    rsp_beat    <= rsp_beat_next;
  end

`ifndef SYNTHESIS
  // Fill count never passes the table size
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= COUNT_W'(TABLE_DEPTH))
    else $error("rule count exceeds table depth");

  // A scan only runs over a non-empty table
  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (total != '0))
    else $error("scan started on empty table");

  // An accepted clear empties the table
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd_beat.cmd == CMD_CLEAR)) |=> (total == '0))
    else $error("clear did not empty the table");

  // A response with an error never reports success
  a_error_denies: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_beat.error != ERR_NONE)) |-> !rsp_beat.allowed)
    else $error("error response marked allowed");
`endif

endmodule
